// ===== src/cbsm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbsm_pkg
// Shared types and constants of the cartridge bank-switching mapper.
// ----------------------------------------------------------------------------
package cbsm_pkg;

   localparam int ROM_BYTES_DEFAULT = 131072;
   localparam int RAM_BYTES         = 32768;
   localparam int RAM_AW            = $clog2(RAM_BYTES);
   localparam int REQ_TDATA_W       = 48;
   localparam int RSP_TDATA_W       = 8;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_LOAD  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [12:0] addr;
      logic [7:0]  data;
      logic [16:0] rom_index;
   } req_item_type;

   typedef struct packed {
      logic        en;
      logic        qual;
      logic [12:0] addr;
      logic [7:0]  data;
   } bank_req_type;

   typedef struct packed {
      logic [4:0] low_bank;
      logic       low_rom;
      logic [4:0] mid_bank;
      logic       mid_rom;
      logic [7:0] high_bank;
      logic       high_rom;
   } bank_state_type;

endpackage

// ===== src/cbsm_ram.sv =====
// ----------------------------------------------------------------------------
// cbsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cbsm_bank.sv =====
// ----------------------------------------------------------------------------
// cbsm_bank
// Bank registers and hotspot decode: low, middle and high slice selection.
// ----------------------------------------------------------------------------
module cbsm_bank (
   input  logic                   clock,
   input  logic                   reset,
   input  cbsm_pkg::bank_req_type bank_req,
   output cbsm_pkg::bank_state_type bank_state
);

   cbsm_pkg::bank_state_type bank_ff;
   cbsm_pkg::bank_state_type bank_in;
   logic [12:0]              a;
   logic [7:0]               d;

   assign a = bank_req.addr;
   assign d = bank_req.data;

   always_comb begin
      bank_in = bank_ff;
      if (bank_req.en && !a[12]) begin
         if (bank_req.qual) begin
            if (a[11:8] == 4'hc) begin
               bank_in.high_bank = a[7:0];
               bank_in.high_rom  = 1'b1;
            end else if (a[11:8] == 4'hd) begin
               bank_in.high_bank = {1'b0, a[6:0]};
               bank_in.high_rom  = 1'b0;
            end else if (a[11:8] == 4'he && !a[6]) begin
               bank_in.low_bank = a[4:0];
               bank_in.low_rom  = 1'b1;
            end else if (a[11:8] == 4'he && a[6]) begin
               bank_in.low_bank = {1'b0, a[3:0]};
               bank_in.low_rom  = 1'b0;
            end else if (a[11:8] == 4'hf && !a[6]) begin
               bank_in.mid_bank = a[4:0];
               bank_in.mid_rom  = 1'b1;
            end else if (a[11:8] == 4'hf && a[6] && !a[4]) begin
               bank_in.mid_bank = {1'b0, a[3:0]};
               bank_in.mid_rom  = 1'b0;
            end else if (a[11:8] == 4'h4) begin
               bank_in.low_bank[0] = ~bank_ff.low_bank[0];
            end else if (a[11:8] == 4'h5) begin
               bank_in.low_bank[1] = ~bank_ff.low_bank[1];
            end else if (a[11:8] == 4'h8) begin
               bank_in.mid_bank[0] = ~bank_ff.mid_bank[0];
            end else if (a[11:8] == 4'h9) begin
               bank_in.mid_bank[1] = ~bank_ff.mid_bank[1];
            end
         end
         if (a[11:8] == 4'h0 && a[6:4] == 3'b111 && a[2] && !a[0]) begin
            bank_in.high_bank = d;
            bank_in.high_rom  = 1'b1;
         end else if (a[11:8] == 4'h0 && a[6:4] == 3'b111 && a[2] && a[0]) begin
            bank_in.high_bank = {1'b0, d[6:0]};
            bank_in.high_rom  = 1'b0;
         end else if (a[11:8] == 4'h0 && a[6:2] == 5'b11110) begin
            case (d[7:4])
               4'h0: begin
                  bank_in.low_bank = {1'b0, d[3:0]};
                  bank_in.low_rom  = 1'b1;
               end
               4'h4: begin
                  bank_in.low_bank = {1'b0, d[3:0]};
                  bank_in.low_rom  = 1'b0;
               end
               4'h9: begin
                  bank_in.mid_bank = {1'b1, d[3:0]};
                  bank_in.mid_rom  = 1'b1;
               end
               4'hc: begin
                  bank_in.mid_bank = {1'b0, d[3:0]};
                  bank_in.mid_rom  = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
      // top page access under the qualifying condition
      if (bank_req.en && bank_req.qual && a[12:8] == 5'h1f) begin
         bank_in.high_bank[3:0] = {a[3], a[6:4]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= '{low_bank: 5'd0, low_rom: 1'b1, mid_bank: 5'd0, mid_rom: 1'b1,
                      high_bank: 8'd0, high_rom: 1'b1};
      end else begin
         bank_ff <= bank_in;
      end
   end

   assign bank_state = bank_ff;

endmodule

// ===== src/cartridge_bank_switch_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_switch_mapper
// Bank-switching cartridge mapper: one bus access or ROM load per transaction.
//
//   channel | ports                   | payload
//   req     | req_tvalid/tready/tdata | func, bus_address, bus_data, rom_index
//   rsp     | rsp_tvalid/tready/tdata | data_out
//
// One transaction per cycle while the response is not stalled; a request passes the
// input register, then the registered read of the ROM or RAM array.
// After reset a pass zeroes all 32768 RAM bytes; req_tready stays low then.
// A stalled response holds the input register; req_tready follows.
// ----------------------------------------------------------------------------
module cartridge_bank_switch_mapper #(
   parameter int ROM_BYTES = cbsm_pkg::ROM_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // func[1:0], bus_address[17:2], bus_data[25:18], rom_index[42:26], zero pad
   input  logic [cbsm_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // data_out[7:0]
   output logic [cbsm_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int ROM_AW = $clog2(ROM_BYTES);
   localparam int RAM_AW = cbsm_pkg::RAM_AW;

   // clearing pass
   logic              clearing_ff, clearing_in;
   logic [RAM_AW-1:0] clr_cnt_ff, clr_cnt_in;

   // input stage
   logic                   a_vld_ff, a_vld_in;
   cbsm_pkg::req_item_type a_item_ff, a_item_in;
   logic                   a_adv;
   logic                   req_take;

   // result stage
   logic       b_vld_ff, b_vld_in;
   logic [7:0] b_data_ff, b_data_in;
   logic       b_mem_ff, b_mem_in;
   logic       b_rom_ff, b_rom_in;
   logic       b_upd_ff, b_upd_in;
   logic       b_addr_ok_ff, b_addr_ok_in;
   logic       prev_qual_ff, prev_qual_in;
   logic [7:0] b_out;
   logic       b_match;
   logic       qual;

   cbsm_pkg::bank_req_type   bank_req;
   cbsm_pkg::bank_state_type bank;

   logic [12:0] a;
   logic        is_rd, is_wr, is_acc;
   logic        sl_low, sl_mid, sl_high, sl_top, slice_rom;
   logic [16:0] rom_addr17;
   logic [15:0] ram_addr16;

   logic              rom_wr_en, rom_rd_en;
   logic [ROM_AW-1:0] rom_wr_addr, rom_rd_addr;
   logic [7:0]        rom_q;
   logic              ram_wr_en, ram_rd_en;
   logic [RAM_AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]        ram_wr_data, ram_q;

   assign req_tready = !clearing_ff && (!a_vld_ff || a_adv);
   assign req_take   = req_tvalid && req_tready;
   assign a_adv      = a_vld_ff && (!b_vld_ff || rsp_tready);

   assign a      = a_item_ff.addr;
   assign is_rd  = a_item_ff.func == cbsm_pkg::FUNC_READ;
   assign is_wr  = a_item_ff.func == cbsm_pkg::FUNC_WRITE;
   assign is_acc = is_rd || is_wr;

   assign sl_low  = a[12:11] == 2'b10;
   assign sl_mid  = a[12:11] == 2'b11 && a[10:9] != 2'b11;
   assign sl_high = a[12:8] == 5'h1e;
   assign sl_top  = a[12:8] == 5'h1f;

   always_comb begin
      slice_rom  = 1'b1;
      rom_addr17 = {9'h1ff, a[7:0]};
      ram_addr16 = {bank.high_bank, a[7:0]};
      if (sl_low) begin
         slice_rom  = bank.low_rom;
         rom_addr17 = {1'b0, bank.low_bank, a[10:0]};
         ram_addr16 = {bank.low_bank, a[10:0]};
      end else if (sl_mid) begin
         slice_rom  = bank.mid_rom;
         rom_addr17 = {1'b1, bank.mid_bank, a[10:0]};
         ram_addr16 = {bank.mid_bank, a[10:0]};
      end else if (sl_high) begin
         slice_rom  = bank.high_rom;
         rom_addr17 = {1'b1, bank.high_bank, a[7:0]};
      end else if (sl_top) begin
         slice_rom = 1'b1;
      end
   end

   // previous access forwarded from the result stage while it is still there
   assign b_match = b_out[7:5] == 3'b011;
   assign qual    = (b_vld_ff && b_upd_ff) ? (b_match && b_addr_ok_ff) : prev_qual_ff;

   assign bank_req = '{en: a_adv && is_acc, qual: qual, addr: a, data: a_item_ff.data};

   cbsm_bank u_bank (
      .clock      (clock),
      .reset      (reset),
      .bank_req   (bank_req),
      .bank_state (bank)
   );

   assign rom_wr_en   = a_adv && a_item_ff.func == cbsm_pkg::FUNC_LOAD;
   assign rom_wr_addr = a_item_ff.rom_index[ROM_AW-1:0];
   assign rom_rd_en   = a_adv && is_rd && a[12] && slice_rom;
   assign rom_rd_addr = rom_addr17[ROM_AW-1:0];

   assign ram_rd_en   = a_adv && is_rd && a[12] && !slice_rom;
   assign ram_rd_addr = ram_addr16[RAM_AW-1:0];
   assign ram_wr_en   = clearing_ff || (a_adv && is_wr && a[12] && !slice_rom);
   assign ram_wr_addr = clearing_ff ? clr_cnt_ff : ram_addr16[RAM_AW-1:0];
   assign ram_wr_data = clearing_ff ? 8'd0 : a_item_ff.data;

   cbsm_ram #(
      .WIDTH (8),
      .DEPTH (ROM_BYTES)
   ) u_rom (
      .clock   (clock),
      .wr_en   (rom_wr_en),
      .wr_addr (rom_wr_addr),
      .wr_data (a_item_ff.data),
      .rd_en   (rom_rd_en),
      .rd_addr (rom_rd_addr),
      .rd_data (rom_q)
   );

   cbsm_ram #(
      .WIDTH (8),
      .DEPTH (cbsm_pkg::RAM_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   assign b_out      = b_mem_ff ? (b_rom_ff ? rom_q : ram_q) : b_data_ff;
   assign rsp_tvalid = b_vld_ff;
   assign rsp_tdata  = b_out;

   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + RAM_AW'(1);
         if (&clr_cnt_ff) begin
            clearing_in = 1'b0;
         end
      end

      a_vld_in  = a_adv ? 1'b0 : a_vld_ff;
      a_item_in = a_item_ff;
      if (req_take) begin
         a_vld_in  = 1'b1;
         a_item_in = '{func:      cbsm_pkg::func_type'(req_tdata[1:0]),
                       addr:      req_tdata[14:2],
                       data:      req_tdata[25:18],
                       rom_index: req_tdata[42:26]};
      end

      b_vld_in     = (b_vld_ff && !rsp_tready) || a_adv;
      b_data_in    = b_data_ff;
      b_mem_in     = b_mem_ff;
      b_rom_in     = b_rom_ff;
      b_upd_in     = b_upd_ff;
      b_addr_ok_in = b_addr_ok_ff;
      if (a_adv) begin
         b_data_in    = a_item_ff.data;
         b_mem_in     = is_rd && a[12];
         b_rom_in     = slice_rom;
         b_upd_in     = is_acc;
         b_addr_ok_in = a[12] || a[12:9] == 4'h0;
      end

      prev_qual_in = prev_qual_ff;
      if (b_vld_ff && rsp_tready && b_upd_ff) begin
         prev_qual_in = b_match && b_addr_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         prev_qual_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         a_vld_ff     <= a_vld_in;
         b_vld_ff     <= b_vld_in;
         prev_qual_ff <= prev_qual_in;
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff    <= a_item_in;
      b_data_ff    <= b_data_in;
      b_mem_ff     <= b_mem_in;
      b_rom_ff     <= b_rom_in;
      b_upd_ff     <= b_upd_in;
      b_addr_ok_ff <= b_addr_ok_in;
   end

   assert property (@(posedge clock) disable iff (reset) clearing_ff |-> !req_tready)
      else $error("request taken during RAM clearing pass");

   assert property (@(posedge clock) disable iff (reset) !(ram_rd_en && ram_wr_en))
      else $error("RAM read and write issued in the same cycle");

   assert property (@(posedge clock) disable iff (reset) a_adv |=> b_vld_ff)
      else $error("advanced transaction missing from result stage");

   assert property (@(posedge clock) disable iff (reset)
      b_vld_ff && !rsp_tready |-> !rom_rd_en && !ram_rd_en)
      else $error("memory read while a stalled response depends on its output");

endmodule

// ===== verif/bank_map_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bank_map_checker
// Watches both channels of the cartridge bank-switching mapper, predicts the
// data_out of every accepted access from its own copy of the banking registers,
// RAM and ROM, and compares each returned byte with the oldest prediction.
// ----------------------------------------------------------------------------
module bank_map_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [cbsm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [cbsm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                               fail_count,
   output int                               pending,
   output logic [15:0]                      low_base,
   output logic [15:0]                      mid_base,
   output logic [15:0]                      high_base,
   output logic                             low_rom,
   output logic                             mid_rom,
   output logic                             high_rom
);

   logic [15:0] prev_addr;
   logic [7:0]  prev_data;
   logic [7:0]  ram [0:cbsm_pkg::RAM_BYTES-1];
   logic [7:0]  rom [0:cbsm_pkg::ROM_BYTES_DEFAULT-1];
   logic [7:0]  expected_data_out [$];

   function automatic bit qualified();
      return (prev_data & 8'he0) == 8'h60 && (prev_addr >= 16'h1000 || prev_addr < 16'h0200);
   endfunction

   task automatic switch_banks(input logic [12:0] a, input logic [7:0] d);
      if (qualified()) begin
         if (a[11:8] == 4'hc) begin
            high_rom = 1'b1;
            high_base = {a[7:0], 8'h00};
         end else if (a[11:8] == 4'hd) begin
            high_rom = 1'b0;
            high_base = {1'b0, a[6:0], 8'h00};
         end else if ((a & 13'h0f40) == 13'h0e00) begin
            low_rom = 1'b1;
            low_base = {a[4:0], 11'b0};
         end else if ((a & 13'h0f40) == 13'h0e40) begin
            low_rom = 1'b0;
            low_base = {1'b0, a[3:0], 11'b0};
         end else if ((a & 13'h0f40) == 13'h0f00) begin
            mid_rom = 1'b1;
            mid_base = {a[4:0], 11'b0};
         end else if ((a & 13'h0f50) == 13'h0f40) begin
            mid_rom = 1'b0;
            mid_base = {1'b0, a[3:0], 11'b0};
         end else if (a[11:8] == 4'h4) begin
            low_base = low_base ^ 16'h0800;
         end else if (a[11:8] == 4'h5) begin
            low_base = low_base ^ 16'h1000;
         end else if (a[11:8] == 4'h8) begin
            mid_base = mid_base ^ 16'h0800;
         end else if (a[11:8] == 4'h9) begin
            mid_base = mid_base ^ 16'h1000;
         end
      end
      if ((a & 13'h0f75) == 13'h0074) begin
         high_rom = 1'b1;
         high_base = {d, 8'h00};
      end else if ((a & 13'h0f75) == 13'h0075) begin
         high_rom = 1'b0;
         high_base = {1'b0, d[6:0], 8'h00};
      end else if ((a & 13'h0f7c) == 13'h0078) begin
         case (d[7:4])
            4'h0: begin
               low_rom = 1'b1;
               low_base = {1'b0, d[3:0], 11'b0};
            end
            4'h4: begin
               low_rom = 1'b0;
               low_base = {1'b0, d[3:0], 11'b0};
            end
            4'h9: begin
               mid_rom = 1'b1;
               mid_base = {1'b1, d[3:0], 11'b0};
            end
            4'hc: begin
               mid_rom = 1'b0;
               mid_base = {1'b0, d[3:0], 11'b0};
            end
            default: ;
         endcase
      end
   endtask

   task automatic predict_bus_access(input logic [cbsm_pkg::REQ_TDATA_W-1:0] t);
      cbsm_pkg::func_type f;
      logic [12:0]        a;
      logic [7:0]         d;
      logic [16:0]        idx;
      logic [16:0]        slot;
      f = cbsm_pkg::func_type'(t[1:0]);
      a = t[14:2];
      d = t[25:18];
      idx = t[42:26];
      if (f == cbsm_pkg::FUNC_LOAD) begin
         rom[idx] = d;
      end else if (f != cbsm_pkg::FUNC_NONE) begin
         if (!a[12]) begin
            switch_banks(a, d);
         end else if (!a[11]) begin
            slot = {1'b0, low_base} + {6'b0, a[10:0]};
            if (f == cbsm_pkg::FUNC_READ) d = low_rom ? rom[slot] : ram[slot[14:0]];
            else if (!low_rom) ram[slot[14:0]] = d;
         end else if (a <= 13'h1dff) begin
            slot = 17'h10000 + {1'b0, mid_base} + {6'b0, a[10:0]};
            if (f == cbsm_pkg::FUNC_READ) d = mid_rom ? rom[slot] : ram[slot[14:0]];
            else if (!mid_rom) ram[slot[14:0]] = d;
         end else if (a <= 13'h1eff) begin
            slot = 17'h10000 + {1'b0, high_base} + {9'b0, a[7:0]};
            if (f == cbsm_pkg::FUNC_READ) d = high_rom ? rom[slot] : ram[slot[14:0]];
            else if (!high_rom) ram[slot[14:0]] = d;
         end else begin
            if (f == cbsm_pkg::FUNC_READ) d = rom[{9'h1ff, a[7:0]}];
            if (qualified()) high_base[11:8] = {a[3], a[6:4]};
         end
         prev_data = d;
         prev_addr = {3'b000, a};
      end
      expected_data_out.push_back(d);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         low_base = '0;
         mid_base = '0;
         high_base = '0;
         low_rom = 1'b1;
         mid_rom = 1'b1;
         high_rom = 1'b1;
         prev_addr = 16'hffff;
         prev_data = 8'hff;
         foreach (ram[i]) ram[i] = 8'h00;
         expected_data_out.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_data_out.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: rsp transaction with none predicted, data_out %02h",
                           $realtime, rsp_tdata);
               fail_count++;
            end else begin
               if (rsp_tdata !== expected_data_out[0]) begin
                  if (fail_count < 10)
                     $display("%0t: data_out mismatch, expected %02h, got %02h",
                              $realtime, expected_data_out[0], rsp_tdata);
                  fail_count++;
               end
               void'(expected_data_out.pop_front());
            end
         end
         if (req_tvalid && req_tready) predict_bus_access(req_tdata);
      end
      pending = expected_data_out.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the cartridge bank-switching mapper: directed accesses over
// the slice edges and switching hotspots, then phases of random access
// sequences under source gaps, sink stalls and a long sink hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT = 100000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 10;
   localparam int PHASE_ITEMS    = 135;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // func[1:0], bus_address[17:2], bus_data[25:18], rom_index[42:26], zero pad
   logic [cbsm_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // data_out[7:0]
   logic [cbsm_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   int          fail_count;
   int          pending;
   logic [15:0] low_base;
   logic [15:0] mid_base;
   logic [15:0] high_base;
   logic        low_rom;
   logic        mid_rom;
   logic        high_rom;

   bit rom_loaded [0:cbsm_pkg::ROM_BYTES_DEFAULT-1];
   int gap_pct = 0;
   int stall_pct = 0;
   bit hold_request = 1'b0;
   int idle_cycles = 0;
   int func_count [4];
   int item_count = 0;
   int phase_end;

   always #4 clock = ~clock;

   cartridge_bank_switch_mapper u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bank_map_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending),
      .low_base   (low_base),
      .mid_base   (mid_base),
      .high_base  (high_base),
      .low_rom    (low_rom),
      .mid_rom    (mid_rom),
      .high_rom   (high_rom)
   );

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $realtime, WATCHDOG_LIMIT, pending);
            $display("cartridge_bank_switch_mapper regression: fail");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic bit rom_slot(input logic [15:0] addr, output logic [16:0] slot);
      logic [12:0] a;
      a = addr[12:0];
      if (!a[12]) return 1'b0;
      if (!a[11]) begin
         slot = {1'b0, low_base} + {6'b0, a[10:0]};
         return low_rom;
      end
      if (a <= 13'h1dff) begin
         slot = 17'h10000 + {1'b0, mid_base} + {6'b0, a[10:0]};
         return mid_rom;
      end
      if (a <= 13'h1eff) begin
         slot = 17'h10000 + {1'b0, high_base} + {9'b0, a[7:0]};
         return high_rom;
      end
      slot = {9'h1ff, a[7:0]};
      return 1'b1;
   endfunction

   // enter and leave at a falling edge; req_tvalid stays high on return
   task automatic offer(input cbsm_pkg::func_type f, input logic [15:0] addr,
                        input logic [7:0] data, input logic [16:0] idx);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {5'b0, idx, data, addr, f};
      req_tvalid <= 1'b1;
      if (f == cbsm_pkg::FUNC_LOAD) rom_loaded[idx] = 1'b1;
      func_count[f]++;
      item_count++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // load the ROM byte a read would hit first, if it was never written
   task automatic send(input cbsm_pkg::func_type f, input logic [15:0] addr,
                       input logic [7:0] data, input logic [16:0] idx);
      logic [16:0] slot;
      logic [7:0]  fill;
      if (f == cbsm_pkg::FUNC_READ && rom_slot(addr, slot) && !rom_loaded[slot]) begin
         fill = 8'($urandom);
         offer(cbsm_pkg::FUNC_LOAD, addr, fill, slot);
      end
      offer(f, addr, data, idx);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_item();
      int                 pick;
      logic [31:0]        r;
      logic [15:0]        addr;
      logic [7:0]         data;
      logic [16:0]        idx;
      cbsm_pkg::func_type rw;
      pick = $urandom_range(99);
      r = $urandom;
      data = 8'($urandom);
      idx = 17'($urandom);
      rw = r[31] ? cbsm_pkg::FUNC_WRITE : cbsm_pkg::FUNC_READ;
      if (pick < 35) begin
         addr = r[30] ? {r[15:13], 4'h0, r[8:0]} : {r[15:13], 1'b1, r[11:0]};
         send(cbsm_pkg::FUNC_WRITE, addr, {3'b011, data[4:0]}, idx);
         r = $urandom;
         rw = r[31] ? cbsm_pkg::FUNC_WRITE : cbsm_pkg::FUNC_READ;
         if (r[30:28] == 3'd0) begin
            addr = {r[15:13], 5'h1f, r[7:0]};
         end else begin
            addr = {r[15:13], 1'b0, 4'h0, r[7:0]};
            case (r[18:16])
               3'd0: addr[11:8] = 4'h4;
               3'd1: addr[11:8] = 4'h5;
               3'd2: addr[11:8] = 4'h8;
               3'd3: addr[11:8] = 4'h9;
               3'd4: addr[11:8] = 4'hc;
               3'd5: addr[11:8] = 4'hd;
               3'd6: addr[11:8] = 4'he;
               default: addr[11:8] = 4'hf;
            endcase
         end
         send(rw, addr, data, idx);
      end else if (pick < 50) begin
         if (r[0]) addr = {r[15:13], 5'h00, r[7], 3'b111, r[3], 1'b1, r[1], r[2]};
         else addr = {r[15:13], 5'h00, r[7], 5'b11110, r[1], r[2]};
         if (r[4]) begin
            case (r[6:5])
               2'd0: data[7:4] = 4'h0;
               2'd1: data[7:4] = 4'h4;
               2'd2: data[7:4] = 4'h9;
               default: data[7:4] = 4'hc;
            endcase
         end
         send(rw, addr, data, idx);
      end else if (pick < 85) begin
         send(rw, {r[15:13], 1'b1, r[11:0]}, data, idx);
      end else if (pick < 93) begin
         send(cbsm_pkg::FUNC_LOAD, r[15:0], data, idx);
      end else begin
         send(cbsm_pkg::func_type'(r[1:0]), r[31:16], data, idx);
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(cbsm_pkg::FUNC_READ,  16'h1000, 8'h00, 17'h00000);
      send(cbsm_pkg::FUNC_READ,  16'h17ff, 8'hff, 17'h1ffff);
      send(cbsm_pkg::FUNC_READ,  16'hffff, 8'h00, 17'h00000);
      send(cbsm_pkg::FUNC_READ,  16'h1e00, 8'h00, 17'h00000);
      send(cbsm_pkg::FUNC_READ,  16'h1dff, 8'h00, 17'h00000);
      send(cbsm_pkg::FUNC_NONE,  16'hffff, 8'hff, 17'h1ffff);
      send(cbsm_pkg::FUNC_LOAD,  16'h0000, 8'h00, 17'h1ffff);
      send(cbsm_pkg::FUNC_READ,  16'h1fff, 8'h5a, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h1000, 8'h60, 17'h00000);
      send(cbsm_pkg::FUNC_READ,  16'h0e41, 8'h00, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h17ff, 8'ha5, 17'h00000);
      send(cbsm_pkg::FUNC_READ,  16'h17ff, 8'h00, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h00f5, 8'hff, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h1eff, 8'h3c, 17'h00000);
      send(cbsm_pkg::FUNC_READ,  16'h1eff, 8'h00, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h0078, 8'h9f, 17'h00000);
      send(cbsm_pkg::FUNC_READ,  16'h1800, 8'h00, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h007b, 8'hc2, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h1dff, 8'h81, 17'h00000);
      send(cbsm_pkg::FUNC_READ,  16'h1dff, 8'h00, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h0074, 8'h80, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h0078, 8'h45, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h0100, 8'h7f, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h1f38, 8'h00, 17'h00000);
      send(cbsm_pkg::FUNC_READ,  16'h1e10, 8'h00, 17'h00000);
      send(cbsm_pkg::FUNC_WRITE, 16'h0200, 8'h60, 17'h00000);
      send(cbsm_pkg::FUNC_READ,  16'h0c12, 8'h00, 17'h00000);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 67; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 67; end
            default: begin gap_pct = 13; stall_pct = 13; end
         endcase
         // hold the sink off while the source keeps offering
         if (phase == 0) hold_request = 1'b1;
         phase_end = item_count + PHASE_ITEMS;
         while (item_count < phase_end) random_item();
         drain();
      end

      $display("Covered %0d transactions: %0d reads, %0d writes, %0d ROM loads, %0d unused",
               item_count, func_count[cbsm_pkg::FUNC_READ], func_count[cbsm_pkg::FUNC_WRITE],
               func_count[cbsm_pkg::FUNC_LOAD], func_count[cbsm_pkg::FUNC_NONE]);
      $display("Traffic ran gap-free, with source gaps, sink stalls, both, and a %0d-cycle hold-off",
               HOLDOFF_CYCLES);
      if (fail_count == 0) begin
         $display("cartridge_bank_switch_mapper regression: pass");
      end else begin
         $display("%0d failures", fail_count);
         $display("cartridge_bank_switch_mapper regression: fail");
      end
      $finish;
   end

endmodule
